// ===== src/fpds_pkg.sv =====
// ----------------------------------------------------------------------------
// fpds_pkg
// Types and constants for the fieldbus point decoder and scaler.
// ----------------------------------------------------------------------------
package fpds_pkg;

  localparam logic REQ_CONVERT = 1'b0;
  localparam logic REQ_LOAD    = 1'b1;

  localparam logic [4:0] DT_BITS      = 5'd0;
  localparam logic [4:0] DT_U16_AB    = 5'd1;
  localparam logic [4:0] DT_S16_AB    = 5'd2;
  localparam logic [4:0] DT_U16_BA    = 5'd3;
  localparam logic [4:0] DT_S16_BA    = 5'd4;
  localparam logic [4:0] DT_U32_ABCD  = 5'd5;
  localparam logic [4:0] DT_S32_ABCD  = 5'd6;
  localparam logic [4:0] DT_U32_BADC  = 5'd7;
  localparam logic [4:0] DT_S32_BADC  = 5'd8;
  localparam logic [4:0] DT_U32_CDAB  = 5'd9;
  localparam logic [4:0] DT_S32_CDAB  = 5'd10;
  localparam logic [4:0] DT_U32_DCBA  = 5'd11;
  localparam logic [4:0] DT_S32_DCBA  = 5'd12;
  localparam logic [4:0] DT_ENUM      = 5'd17;
  localparam logic [4:0] DT_BITS_ENUM = 5'd18;

  localparam logic [1:0] ST_U16 = 2'd0;
  localparam logic [1:0] ST_S16 = 2'd1;
  localparam logic [1:0] ST_U32 = 2'd2;
  localparam logic [1:0] ST_S32 = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic        [63:0] data_bytes;
    logic        [2:0]  byte_offset;
    logic        [4:0]  data_type;
    logic        [3:0]  field_msb;
    logic        [3:0]  field_lsb;
    logic signed [31:0] scale_factor;
    logic signed [47:0] offset_value;
    logic        [1:0]  store_type;
    logic        [8:0]  word_index;
    logic        [5:0]  enum_base;
    logic        [4:0]  enum_count;
  } in_req_t;

  typedef struct packed {
    logic [8:0]  out_index;
    logic [15:0] word_value;
    logic        last_word;
  } out_req_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EREQ, S_EWAIT, S_ECMP, S_MUL, S_SUM, S_OUT_HI, S_OUT_LO
  } state_t;

  function automatic logic [15:0] bit_field(input logic [15:0] src,
                                            input logic [3:0] msb,
                                            input logic [3:0] lsb);
    logic [15:0] sh;
    logic [15:0] mask;
    sh   = src >> lsb;
    mask = 16'hffff >> (4'd15 - (msb - lsb));
    bit_field = (lsb > msb) ? 16'd0 : (sh & mask);
  endfunction

endpackage

// ===== src/fpds_ram.sv =====
// ----------------------------------------------------------------------------
// fpds_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module fpds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/fpds_decode.sv =====
// ----------------------------------------------------------------------------
// fpds_decode
// Byte-order and bit-field decode of the point's raw bytes.
// ----------------------------------------------------------------------------
module fpds_decode (
  input  logic [63:0]        data_bytes,
  input  logic [2:0]         byte_offset,
  input  logic [4:0]         data_type,
  input  logic [3:0]         field_msb,
  input  logic [3:0]         field_lsb,
  input  logic               bus_kind,
  output logic signed [32:0] value,
  output logic               is_enum,
  output logic [15:0]        enum_key,
  output logic               known
);
  import fpds_pkg::*;

  logic [127:0] ext;
  logic [7:0]   a, b, c, d;
  logic [15:0]  w16;
  logic [31:0]  w32;
  logic [3:0]   msb8;

  assign ext  = {64'd0, data_bytes} >> {byte_offset, 3'b000};
  assign a    = ext[7:0];
  assign b    = ext[15:8];
  assign c    = ext[23:16];
  assign d    = ext[31:24];
  assign w16  = {a, b};
  assign msb8 = (field_msb > 4'd7) ? 4'd7 : field_msb;

  always_comb begin
    value    = '0;
    is_enum  = 1'b0;
    enum_key = '0;
    known    = 1'b1;
    w32      = '0;
    case (data_type)
      DT_BITS:   value = {17'd0, bit_field({8'd0, a}, msb8, field_lsb)};
      DT_U16_AB: value = {17'd0, w16};
      DT_S16_AB: value = {{17{w16[15]}}, w16};
      DT_U16_BA: value = {17'd0, b, a};
      DT_S16_BA: value = {{17{b[7]}}, b, a};
      DT_U32_ABCD, DT_S32_ABCD, DT_U32_BADC, DT_S32_BADC,
      DT_U32_CDAB, DT_S32_CDAB, DT_U32_DCBA, DT_S32_DCBA: begin
        if (data_type inside {DT_U32_ABCD, DT_S32_ABCD}) begin
          w32 = {a, b, c, d};
        end else if (data_type inside {DT_U32_BADC, DT_S32_BADC}) begin
          w32 = {b, a, d, c};
        end else if (data_type inside {DT_U32_CDAB, DT_S32_CDAB}) begin
          w32 = {c, d, a, b};
        end else begin
          w32 = {d, c, b, a};
        end
        value = {~data_type[0] & w32[31], w32};
      end
      DT_ENUM: begin
        is_enum  = 1'b1;
        enum_key = bus_kind ? {8'd0, a} : w16;
      end
      DT_BITS_ENUM: begin
        is_enum  = 1'b1;
        enum_key = bus_kind ? bit_field({8'd0, a}, msb8, field_lsb)
                            : bit_field(w16, field_msb, field_lsb);
      end
      default: known = 1'b0;
    endcase
  end
endmodule

// ===== src/fieldbus_point_decode_scale.sv =====
// ----------------------------------------------------------------------------
// fieldbus_point_decode_scale
// Decodes a fieldbus point, scales it in fixed point and emits node words.
// ----------------------------------------------------------------------------
// A convert request is decoded first, then each enum entry searched takes a
// table RAM read (S_EWAIT) and then the compare (S_ECMP), then come the
// multiply and the offset add unless the result is forced to 0. It then
// presents one or two node words, each held until taken. A non-enum convert
// passes S_EREQ, S_MUL and S_SUM before its first word. A load request
// writes one enum entry at its accept edge, and the block is ready again on
// the next cycle. The block accepts one request at a time.
module fieldbus_point_decode_scale #(
  parameter int ENUM_ENTRIES    = 64,
  parameter int NODE_WORDS      = 512,
  parameter int ENUM_SEARCH_MAX = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpds_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpds_pkg::out_req_t out_data
);
  import fpds_pkg::*;

  localparam int EAW = $clog2(ENUM_ENTRIES);
  localparam int NAW = $clog2(NODE_WORDS);
  localparam int CW  = $clog2(ENUM_SEARCH_MAX + 1);

  state_t state, state_next;
  logic   bus_kind;
  in_req_t req;

  logic signed [32:0] dec_value;
  logic               dec_enum, dec_known;
  logic [15:0]        dec_key;

  logic [EAW-1:0] eidx;
  logic [CW-1:0]  eleft;
  logic [31:0]    rdata;
  logic           ram_we;

  logic signed [32:0] v;
  logic signed [65:0] prod;
  logic [31:0]        res_word;
  logic [NAW-1:0]     widx;

  fpds_decode u_decode (
    .data_bytes (req.data_bytes),
    .byte_offset(req.byte_offset),
    .data_type  (req.data_type),
    .field_msb  (req.field_msb),
    .field_lsb  (req.field_lsb),
    .bus_kind   (bus_kind),
    .value      (dec_value),
    .is_enum    (dec_enum),
    .enum_key   (dec_key),
    .known      (dec_known)
  );

  assign ram_we = in_valid && in_ready && (in_data.req_type == REQ_LOAD);

  fpds_ram #(.WIDTH(32), .DEPTH(ENUM_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(EAW'(in_data.enum_base)),
    .wdata(in_data.data_bytes[31:0]),
    .raddr(eidx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_kind <= 1'b0;
    end else if (cfg_we) begin
      bus_kind <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (in_valid && in_data.req_type == REQ_CONVERT) begin
          state_next = S_EREQ;
        end
      S_EREQ: begin
        if (!dec_known) begin
          state_next = S_OUT_HI;
        end else if (!dec_enum) begin
          state_next = S_MUL;
        end else if (eleft == '0) begin
          state_next = S_OUT_HI;
        end else begin
          state_next = S_EWAIT;
        end
      end
      S_EWAIT: state_next = S_ECMP;
      S_ECMP: begin
        if (rdata[31:16] == dec_key) begin
          state_next = S_MUL;
        end else if (eleft == '0) begin
          state_next = S_OUT_HI;
        end else begin
          state_next = S_EWAIT;
        end
      end
      S_MUL: state_next = S_SUM;
      S_SUM: state_next = S_OUT_HI;
      S_OUT_HI:
        if (out_ready) begin
          state_next = req.store_type[1] ? S_OUT_LO : S_IDLE;
        end
      S_OUT_LO:
        if (out_ready) begin
          state_next = S_IDLE;
        end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT_HI) || (state == S_OUT_LO);
    out_data  = '0;
    if (state == S_OUT_LO) begin
      out_data.out_index  = 9'(NAW'(widx + 1'b1));
      out_data.word_value = res_word[15:0];
      out_data.last_word  = 1'b1;
    end else begin
      out_data.out_index  = 9'(widx);
      out_data.word_value = req.store_type[1] ? res_word[31:16] : res_word[15:0];
      out_data.last_word  = ~req.store_type[1];
    end
  end

  logic signed [66:0] lim_p, sum;
  logic signed [50:0] q;
  logic signed [50:0] lo, hi;

  always_comb begin
    lim_p = 67'(prod);
    sum   = lim_p + 67'(req.offset_value);
    q     = 51'((sum < 0) ? -((-sum) >>> 16) : (sum >>> 16));
    unique case (req.store_type)
      ST_U16: begin lo = 51'sd0;           hi = 51'sd65535;      end
      ST_S16: begin lo = -51'sd32768;      hi = 51'sd32767;      end
      ST_U32: begin lo = 51'sd0;           hi = 51'sd4294967295; end
      default: begin lo = -51'sd2147483648; hi = 51'sd2147483647; end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_valid) begin
        req       <= in_data;
        widx      <= NAW'(in_data.word_index);
        eidx      <= EAW'(in_data.enum_base);
        eleft     <= (32'(in_data.enum_count) > ENUM_SEARCH_MAX) ?
                     CW'(ENUM_SEARCH_MAX) : CW'(in_data.enum_count);
        res_word  <= '0;
      end
      S_EREQ: begin
        v <= dec_value;
        if (dec_enum && eleft != '0) begin
          eleft <= eleft - 1'b1;
        end
      end
      S_ECMP: begin
        if (rdata[31:16] == dec_key) begin
          v <= {17'd0, rdata[15:0]};
        end else if (eleft != '0) begin
          eidx  <= eidx + 1'b1;
          eleft <= eleft - 1'b1;
        end
      end
      S_MUL: prod <= v * $signed({{1{req.scale_factor[31]}}, req.scale_factor});
      S_SUM: res_word <= (q < lo) ? lo[31:0] : (q > hi) ? hi[31:0] : q[31:0];
      default: ;
    endcase
  end
endmodule
